FILE: design/bclt_pkg.sv
// ----------------------------------------------------------------------------
// bclt_pkg: shared types and codes of the BLE central link tracker
// Command, request, user event and link state codes, table control, limits.
// ----------------------------------------------------------------------------
`default_nettype none

package bclt_pkg;

   // command codes carried in req_tuser
   localparam logic [2:0] CMD_START_SCAN   = 3'd0;
   localparam logic [2:0] CMD_STOP_SCAN    = 3'd1;
   localparam logic [2:0] CMD_CONNECT      = 3'd2;
   localparam logic [2:0] CMD_DISCONNECT   = 3'd3;
   localparam logic [2:0] CMD_ADV_REPORT   = 3'd4;
   localparam logic [2:0] CMD_CONN_DONE    = 3'd5;
   localparam logic [2:0] CMD_DISCONN_DONE = 3'd6;
   localparam logic [2:0] CMD_PROC_DONE    = 3'd7;

   // user events
   localparam logic [2:0] UEV_NONE         = 3'd0;
   localparam logic [2:0] UEV_SCAN_RESULT  = 3'd1;
   localparam logic [2:0] UEV_CONNECTED    = 3'd2;
   localparam logic [2:0] UEV_CONN_ERROR   = 3'd3;
   localparam logic [2:0] UEV_DISCONNECTED = 3'd4;

   // controller requests
   localparam logic [2:0] REQ_NONE         = 3'd0;
   localparam logic [2:0] REQ_START_DISC   = 3'd1;
   localparam logic [2:0] REQ_TERM_DISC    = 3'd2;
   localparam logic [2:0] REQ_CREATE_CONN  = 3'd3;
   localparam logic [2:0] REQ_TERM_LINK    = 3'd4;

   // link states
   localparam logic [1:0] LINK_IDLE        = 2'd0;
   localparam logic [1:0] LINK_SCAN        = 2'd1;
   localparam logic [1:0] LINK_CONNECTING  = 2'd2;
   localparam logic [1:0] LINK_CONNECTED   = 2'd3;

   localparam logic [15:0] NO_HANDLE       = 16'hFFFF;
   localparam logic [4:0]  ADV_DATA_MAX    = 5'd31;

   localparam int ADDR_W   = 48;
   localparam int REQ_DW   = 104;
   localparam int RSP_DW   = 96;

   // result field positions in rsp_tdata
   localparam int RSP_ACC_LSB   = 0;
   localparam int RSP_UEV_LSB   = 1;
   localparam int RSP_REQ_LSB   = 4;
   localparam int RSP_LINK_LSB  = 7;
   localparam int RSP_HND_LSB   = 9;

   // table control handed along the row of cells
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/bclt_cell.sv
// ----------------------------------------------------------------------------
// bclt_cell: one slot of the seen-address table
// Holds one address and its valid bit, compares it with the search key and
// hands its content to the next cell when a new address enters the row.
// ----------------------------------------------------------------------------
`default_nettype none

module bclt_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bclt_pkg::cell_ctrl_type ctrl,
   input  wire  [47:0]                  key,
   input  wire  [47:0]                  prev_addr,
   input  wire                          prev_valid,
   output logic [47:0]                  addr,
   output logic                         valid,
   output logic                         match
);
   import bclt_pkg::*;

   logic [ADDR_W-1:0] addr_ff;
   logic              valid_ff;
   logic              match_ff;

   // clear on a new scan, take the neighbor's slot on insert
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         addr_ff <= prev_addr;
      end
   end

   // register the compare against the held key
   always_ff @(posedge clock) begin
      match_ff <= valid_ff && (addr_ff == key);
   end

   assign addr  = addr_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

FILE: design/ble_central_link_tracker.sv
// ----------------------------------------------------------------------------
// ble_central_link_tracker: link state tracker of a Bluetooth LE central
// Follows idle, scanning, connecting and connected over host commands and
// controller events, and filters advertising reports through a row of
// seen-address cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_tvalid/tready     tuser command, tdata item fields
//  rsp_      out        rsp_tvalid/tready     tdata result fields
//
//  A transaction passes capture in S_WAIT, the compare of every cell of the
//  row with the address in S_CMP, and the decision that loads the output
//  register in S_DONE. A new transaction is taken while a result waits in
//  the output register; the decision step waits while that register is
//  full and rsp_tready is low.
//  Synchronous reset puts the link in idle, handle 0xFFFF, empty table.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_central_link_tracker #(
   parameter int DEDUP_SLOTS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // command [2:0]
   input  wire  [2:0]   req_tuser,
   // addr [47:0], peer_kind [55:48], rssi [63:56], adv_len [71:64],
   // status [79:72], handle [95:80], is_discovery [96], zero fill
   input  wire  [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // accepted [0], user_event [3:1], request [6:4], link_state [8:7],
   // link_hnd [24:9], rpt_addr [72:25], rpt_kind [80:73],
   // out_rssi [88:81], out_data_len [93:89], zero fill
   output logic [95:0]  rsp_tdata
);
   import bclt_pkg::*;

   typedef enum logic [2:0] {
      S_WAIT = 3'b001,
      S_CMP  = 3'b010,
      S_DONE = 3'b100
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // captured transaction
   logic [2:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        atype_ff;
   logic [7:0]        rssi_ff;
   logic [7:0]        dlen_ff;
   logic [7:0]        status_ff;
   logic [15:0]       hnd_ff;
   logic              disc_ff;

   // link state
   logic [1:0]        link_ff, link_in;
   logic [15:0]       handle_ff, handle_in;
   logic [ADDR_W-1:0] peer_addr_ff, peer_addr_in;
   logic [7:0]        peer_type_ff, peer_type_in;

   // output register
   logic              rsp_valid_ff;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   // cell row
   cell_ctrl_type     cell_ctrl;
   logic [ADDR_W-1:0] chain_addr  [DEDUP_SLOTS+1];
   logic              chain_valid [DEDUP_SLOTS+1];
   logic [DEDUP_SLOTS-1:0] cell_match;

   logic done_fire;
   logic acc;
   logic [2:0] uev, req;
   logic scan_res, insert, tbl_clear, is_new, tbl_full, st_ok, live_link;
   logic [ADDR_W-1:0] r_addr;
   logic [7:0] r_type, r_rssi;
   logic [4:0] r_len;

   assign req_tready = (state_ff == S_WAIT);
   assign done_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequence one transaction
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_WAIT:  if (req_tvalid) state_in = S_CMP;
         S_CMP:   state_in = S_DONE;
         S_DONE:  if (done_fire) state_in = S_WAIT;
         default: state_in = S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff    <= req_tuser;
         addr_ff   <= req_tdata[47:0];
         atype_ff  <= req_tdata[55:48];
         rssi_ff   <= req_tdata[63:56];
         dlen_ff   <= req_tdata[71:64];
         status_ff <= req_tdata[79:72];
         hnd_ff    <= req_tdata[95:80];
         disc_ff   <= req_tdata[96];
      end
   end

   // row of table cells, new addresses enter at cell 0
   assign chain_addr[0]  = addr_ff;
   assign chain_valid[0] = 1'b1;

   for (genvar i = 0; i < DEDUP_SLOTS; i++) begin : g_cell
      bclt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .key        (addr_ff),
         .prev_addr  (chain_addr[i]),
         .prev_valid (chain_valid[i]),
         .addr       (chain_addr[i+1]),
         .valid      (chain_valid[i+1]),
         .match      (cell_match[i])
      );
   end

   assign is_new   = ~(|cell_match);
   assign tbl_full = chain_valid[DEDUP_SLOTS];

   // decide result and next link state
   always_comb begin
      acc          = 1'b0;
      uev          = UEV_NONE;
      req          = REQ_NONE;
      scan_res     = 1'b0;
      insert       = 1'b0;
      tbl_clear    = 1'b0;
      link_in      = link_ff;
      handle_in    = handle_ff;
      peer_addr_in = peer_addr_ff;
      peer_type_in = peer_type_ff;
      st_ok        = (status_ff == 8'd0);
      live_link    = (link_ff == LINK_CONNECTED) || (link_ff == LINK_CONNECTING);
      case (cmd_ff)
         CMD_START_SCAN: begin
            if (link_ff == LINK_IDLE) begin
               tbl_clear = 1'b1;
               req       = REQ_START_DISC;
               if (st_ok) begin
                  link_in = LINK_SCAN;
                  acc     = 1'b1;
               end
            end
         end
         CMD_STOP_SCAN: begin
            if (link_ff != LINK_SCAN) begin
               acc = 1'b1;
            end else begin
               req = REQ_TERM_DISC;
               acc = st_ok;
            end
         end
         CMD_CONNECT: begin
            if (link_ff == LINK_IDLE) begin
               peer_addr_in = addr_ff;
               peer_type_in = atype_ff;
               req          = REQ_CREATE_CONN;
               if (st_ok) begin
                  link_in = LINK_CONNECTING;
                  acc     = 1'b1;
               end
            end
         end
         CMD_DISCONNECT: begin
            if (live_link && (handle_ff != NO_HANDLE)) begin
               req = REQ_TERM_LINK;
               acc = st_ok;
            end else begin
               acc = 1'b1;
            end
         end
         CMD_ADV_REPORT: begin
            acc = 1'b1;
            if ((link_ff == LINK_SCAN) && is_new) begin
               scan_res = 1'b1;
               uev      = UEV_SCAN_RESULT;
               insert   = !tbl_full;
            end
         end
         CMD_CONN_DONE: begin
            if (link_ff == LINK_CONNECTING) begin
               acc = 1'b1;
               if (st_ok) begin
                  link_in      = LINK_CONNECTED;
                  handle_in    = hnd_ff;
                  peer_addr_in = addr_ff;
                  peer_type_in = atype_ff;
                  uev          = UEV_CONNECTED;
               end else begin
                  link_in   = LINK_IDLE;
                  handle_in = NO_HANDLE;
                  uev       = UEV_CONN_ERROR;
               end
            end
         end
         CMD_DISCONN_DONE: begin
            if (live_link && (handle_ff == hnd_ff)) begin
               acc       = 1'b1;
               link_in   = LINK_IDLE;
               handle_in = NO_HANDLE;
               uev       = UEV_DISCONNECTED;
            end
         end
         CMD_PROC_DONE: begin
            if (disc_ff) begin
               acc = 1'b1;
               if (link_ff == LINK_SCAN) link_in = LINK_IDLE;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase

      // report the new peer, else the stored one
      r_addr = scan_res ? addr_ff  : peer_addr_in;
      r_type = scan_res ? atype_ff : peer_type_in;
      r_rssi = scan_res ? rssi_ff  : 8'd0;
      if (!scan_res) begin
         r_len = 5'd0;
      end else if (dlen_ff > {3'd0, ADV_DATA_MAX}) begin
         r_len = ADV_DATA_MAX;
      end else begin
         r_len = dlen_ff[4:0];
      end

      rsp_data_in = {2'd0, r_len, r_rssi, r_type, r_addr, handle_in, link_in,
                     req, uev, acc};
   end

   assign cell_ctrl.clear = done_fire && tbl_clear;
   assign cell_ctrl.shift = done_fire && insert;

   // commit link state when the result is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= LINK_IDLE;
         handle_ff    <= NO_HANDLE;
         peer_addr_ff <= '0;
         peer_type_ff <= '0;
      end else if (done_fire) begin
         link_ff      <= link_in;
         handle_ff    <= handle_in;
         peer_addr_ff <= peer_addr_in;
         peer_type_ff <= peer_type_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/bclt_checker.sv
// ----------------------------------------------------------------------------
// bclt_checker: port-level checks of the BLE central link tracker
// Watches both channels and the link fields of each result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bclt_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [95:0]  rsp_tdata
);
   import bclt_pkg::*;

   logic        r_acc;
   logic [2:0]  r_uev, r_req;
   logic [1:0]  r_link;
   logic [15:0] r_hnd;

   assign r_acc  = rsp_tdata[RSP_ACC_LSB];
   assign r_uev  = rsp_tdata[RSP_UEV_LSB +: 3];
   assign r_req  = rsp_tdata[RSP_REQ_LSB +: 3];
   assign r_link = rsp_tdata[RSP_LINK_LSB +: 2];
   assign r_hnd  = rsp_tdata[RSP_HND_LSB +: 16];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an accepted transaction blocks the input for the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on consecutive cycles");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // connected event leaves the link connected
   a_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r_uev == UEV_CONNECTED) |-> r_acc && (r_link == LINK_CONNECTED))
      else $error("connected event without connected link");

   // idle link carries no handle
   a_idle_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r_link == LINK_IDLE) && (r_req == REQ_NONE) &&
      ((r_uev == UEV_DISCONNECTED) || (r_uev == UEV_CONN_ERROR)) |->
      r_hnd == NO_HANDLE)
      else $error("handle kept after link loss");

endmodule

bind ble_central_link_tracker bclt_checker u_bclt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the BLE central link tracker
// Drives host commands and controller events on the request stream, tracks
// the link state and the seen-address table in a local model, and checks
// every response transaction field by field. A directed table comes first,
// followed by random scan sessions, connect sessions and noise. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import bclt_pkg::*;

   localparam int SLOTS        = 32;
   localparam int ITEM_TARGET  = 1940;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [47:0] addr;
      logic [7:0]  atype;
      logic [7:0]  rssi;
      logic [7:0]  dlen;
      logic [7:0]  status;
      logic [15:0] hnd;
      logic        disc;
   } link_item_type;

   typedef struct packed {
      logic        acc;
      logic [2:0]  uev;
      logic [2:0]  req;
      logic [1:0]  link;
      logic [15:0] hnd;
      logic [47:0] addr;
      logic [7:0]  atype;
      logic [7:0]  rssi;
      logic [4:0]  dlen;
   } outcome_type;

   typedef struct {
      link_item_type it;
      bit            fixed;
      outcome_type   want;
   } plan_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [2:0]    req_tuser = '0;
   // addr, peer kind, rssi, adv length, status, handle, is_discovery, zero fill
   logic [103:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // accepted, user_event, request, link_state, link handle, report address,
   // report address kind, out_rssi, out_data_len, zero fill
   logic [95:0]   rsp_tdata;

   // link tracker model state
   logic [1:0]    m_link;
   logic [15:0]   m_handle;
   logic [47:0]   m_peer;
   logic [7:0]    m_ptype;
   logic [47:0]   seen_addr [SLOTS];
   bit            seen_ok   [SLOTS];
   int            seen_cnt;

   outcome_type   outcome_q[$];
   plan_row_type  plan_q[$];
   logic [47:0]   peer_pool [64];

   bit            calm;
   int            n_items;
   int            n_results;
   int            n_scan_hits;
   int            n_links_up;
   int            n_overflow;
   int            n_mismatch;
   int            cycles;
   int            hold_cnt;
   outcome_type   got;
   outcome_type   want_now;

   ble_central_link_tracker #(.DEDUP_SLOTS(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [47:0] rand_addr();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic logic [7:0] rand_status();
      if ($urandom_range(0, 9) != 0) return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic link_item_type mk(logic [2:0] cmd, logic [47:0] addr, logic [7:0] atype,
                                        logic [7:0] rssi, logic [7:0] dlen, logic [7:0] status,
                                        logic [15:0] hnd, logic disc);
      link_item_type it;
      it.cmd = cmd; it.addr = addr; it.atype = atype; it.rssi = rssi;
      it.dlen = dlen; it.status = status; it.hnd = hnd; it.disc = disc;
      return it;
   endfunction

   function automatic link_item_type noise_item();
      return mk(3'($urandom_range(0, 7)), rand_addr(), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
   endfunction

   // response with the post-reset peer fields and no user event
   function automatic outcome_type reset_outcome(logic acc, logic [2:0] req, logic [1:0] link);
      outcome_type o;
      o = '0;
      o.acc = acc; o.req = req; o.link = link; o.hnd = NO_HANDLE;
      return o;
   endfunction

   // advance the link model by one item and return its response
   function automatic outcome_type advance_link(link_item_type it);
      outcome_type o;
      bit          fresh;
      bit          hit;
      int          i;
      o = '0;
      fresh = 0;
      hit = 0;
      case (it.cmd)
         CMD_START_SCAN: begin
            if (m_link == LINK_IDLE) begin
               for (i = 0; i < SLOTS; i++) seen_ok[i] = 0;
               seen_cnt = 0;
               o.req = REQ_START_DISC;
               if (it.status == 8'h00) begin
                  m_link = LINK_SCAN;
                  o.acc = 1'b1;
               end
            end
         end
         CMD_STOP_SCAN: begin
            if (m_link != LINK_SCAN) o.acc = 1'b1;
            else begin
               o.req = REQ_TERM_DISC;
               o.acc = (it.status == 8'h00);
            end
         end
         CMD_CONNECT: begin
            if (m_link == LINK_IDLE) begin
               m_peer = it.addr;
               m_ptype = it.atype;
               o.req = REQ_CREATE_CONN;
               if (it.status == 8'h00) begin
                  m_link = LINK_CONNECTING;
                  o.acc = 1'b1;
               end
            end
         end
         CMD_DISCONNECT: begin
            if ((m_link == LINK_CONNECTED || m_link == LINK_CONNECTING) &&
                m_handle != NO_HANDLE) begin
               o.req = REQ_TERM_LINK;
               o.acc = (it.status == 8'h00);
            end else o.acc = 1'b1;
         end
         CMD_ADV_REPORT: begin
            o.acc = 1'b1;
            if (m_link == LINK_SCAN) begin
               for (i = 0; i < SLOTS; i++)
                  if (seen_ok[i] && seen_addr[i] == it.addr) hit = 1;
               if (!hit) begin
                  if (seen_cnt < SLOTS) begin
                     seen_addr[seen_cnt] = it.addr;
                     seen_ok[seen_cnt] = 1;
                     seen_cnt++;
                  end else n_overflow++;
                  fresh = 1;
                  o.uev = UEV_SCAN_RESULT;
                  o.addr = it.addr;
                  o.atype = it.atype;
                  o.rssi = it.rssi;
                  o.dlen = (it.dlen > 8'(ADV_DATA_MAX)) ? ADV_DATA_MAX : it.dlen[4:0];
               end
            end
         end
         CMD_CONN_DONE: begin
            if (m_link == LINK_CONNECTING) begin
               o.acc = 1'b1;
               if (it.status == 8'h00) begin
                  m_link = LINK_CONNECTED;
                  m_handle = it.hnd;
                  m_ptype = it.atype;
                  m_peer = it.addr;
                  o.uev = UEV_CONNECTED;
               end else begin
                  m_link = LINK_IDLE;
                  m_handle = NO_HANDLE;
                  o.uev = UEV_CONN_ERROR;
               end
            end
         end
         CMD_DISCONN_DONE: begin
            if ((m_link == LINK_CONNECTED || m_link == LINK_CONNECTING) &&
                m_handle == it.hnd) begin
               o.acc = 1'b1;
               m_link = LINK_IDLE;
               m_handle = NO_HANDLE;
               o.uev = UEV_DISCONNECTED;
            end
         end
         default: begin
            if (it.disc) begin
               o.acc = 1'b1;
               if (m_link == LINK_SCAN) m_link = LINK_IDLE;
            end
         end
      endcase
      if (!fresh) begin
         o.addr = m_peer;
         o.atype = m_ptype;
      end
      o.link = m_link;
      o.hnd = m_handle;
      return o;
   endfunction

   // drive one request transaction and queue its expected response
   task automatic send_item(input link_item_type it, input bit fixed, input outcome_type want);
      int          gap;
      outcome_type model_out;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= it.cmd;
      req_tdata  <= {7'b0, it.disc, it.hnd, it.status, it.dlen, it.rssi, it.atype, it.addr};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_items++;
      model_out = advance_link(it);
      outcome_q.push_back(fixed ? want : model_out);
   endtask

   task automatic send(input link_item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // bring the link back to idle so that a session can start
   task automatic back_to_idle();
      if (m_link == LINK_SCAN)
         send(mk(CMD_PROC_DONE, rand_addr(), 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
      else if (m_link != LINK_IDLE)
         send(mk(CMD_DISCONN_DONE, rand_addr(), 8'h00, 8'h00, 8'h00, 8'h00, m_handle, 1'b0));
   endtask

   // start scan, a burst of reports over a pool of peers, an optional stop and complete
   task automatic scan_session();
      bit          big;
      int          psz;
      int          nrep;
      int          k;
      logic [47:0] a;
      logic [7:0]  dl;
      back_to_idle();
      big = ($urandom_range(0, 3) == 0);
      psz = big ? $urandom_range(33, 48) : $urandom_range(1, 12);
      for (k = 0; k < psz; k++) begin
         case ($urandom_range(0, 15))
            0:       peer_pool[k] = '0;
            1:       peer_pool[k] = '1;
            default: peer_pool[k] = rand_addr();
         endcase
      end
      send(mk(CMD_START_SCAN, rand_addr(), 8'h00, 8'h00, 8'h00, rand_status(), 16'h0000, 1'b0));
      nrep = big ? psz + $urandom_range(0, 10) : $urandom_range(1, 24);
      for (k = 0; k < nrep; k++) begin
         if ($urandom_range(0, 19) == 0) send(noise_item());
         else begin
            if (big && k < psz) a = peer_pool[k];
            else if ($urandom_range(0, 9) == 0) a = rand_addr();
            else a = peer_pool[$urandom_range(0, psz - 1)];
            dl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                             : 8'($urandom_range(0, 255));
            send(mk(CMD_ADV_REPORT, a, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    dl, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1))));
         end
      end
      if ($urandom_range(0, 3) != 0)
         send(mk(CMD_STOP_SCAN, rand_addr(), 8'h00, 8'h00, 8'h00, rand_status(), 16'h0000,
                 1'b0));
      send(mk(CMD_PROC_DONE, rand_addr(), 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
              1'($urandom_range(0, 9) != 0)));
   endtask

   // connect, complete, some traffic, an optional disconnect and disconnection complete
   task automatic connect_session();
      logic [15:0] h;
      int          k;
      back_to_idle();
      case ($urandom_range(0, 7))
         0:       h = 16'h0000;
         1:       h = NO_HANDLE;
         default: h = 16'($urandom_range(0, 65535));
      endcase
      send(mk(CMD_CONNECT, rand_addr(), 8'($urandom_range(0, 255)), 8'h00, 8'h00,
              rand_status(), 16'h0000, 1'b0));
      if ($urandom_range(0, 4) == 0) send(noise_item());
      send(mk(CMD_CONN_DONE, rand_addr(), 8'($urandom_range(0, 255)), 8'h00, 8'h00,
              rand_status(), h, 1'b0));
      for (k = $urandom_range(0, 3); k > 0; k--) send(noise_item());
      if ($urandom_range(0, 3) != 0)
         send(mk(CMD_DISCONNECT, rand_addr(), 8'h00, 8'h00, 8'h00, rand_status(), 16'h0000,
                 1'b0));
      send(mk(CMD_DISCONN_DONE, rand_addr(), 8'h00, 8'h00, 8'h00, 8'h00,
              ($urandom_range(0, 4) != 0) ? m_handle : 16'($urandom_range(0, 65535)), 1'b0));
   endtask

   task automatic note_mismatch(input string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("[%0t] %s", $realtime, msg);
   endtask

   // check each response transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.acc   = rsp_tdata[RSP_ACC_LSB];
         got.uev   = rsp_tdata[RSP_UEV_LSB +: 3];
         got.req   = rsp_tdata[RSP_REQ_LSB +: 3];
         got.link  = rsp_tdata[RSP_LINK_LSB +: 2];
         got.hnd   = rsp_tdata[RSP_HND_LSB +: 16];
         got.addr  = rsp_tdata[72:25];
         got.atype = rsp_tdata[80:73];
         got.rssi  = rsp_tdata[88:81];
         got.dlen  = rsp_tdata[93:89];
         n_results++;
         if (got.uev == UEV_SCAN_RESULT) n_scan_hits++;
         if (got.uev == UEV_CONNECTED) n_links_up++;
         if (outcome_q.size() == 0)
            note_mismatch($sformatf("response with nothing pending: %h", rsp_tdata));
         else begin
            want_now = outcome_q.pop_front();
            if (got.acc !== want_now.acc || got.uev !== want_now.uev ||
                got.req !== want_now.req || got.link !== want_now.link ||
                got.hnd !== want_now.hnd || got.addr !== want_now.addr ||
                got.atype !== want_now.atype || got.rssi !== want_now.rssi ||
                got.dlen !== want_now.dlen)
               note_mismatch($sformatf({"response %0d exp acc %0h uev %0h req %0h link %0h ",
                  "hnd %h addr %h type %h rssi %h len %h / got acc %0h uev %0h req %0h ",
                  "link %0h hnd %h addr %h type %h rssi %h len %h"}, n_results,
                  want_now.acc, want_now.uev, want_now.req, want_now.link, want_now.hnd,
                  want_now.addr, want_now.atype, want_now.rssi, want_now.dlen,
                  got.acc, got.uev, got.req, got.link, got.hnd, got.addr, got.atype,
                  got.rssi, got.dlen));
         end
      end
      // stall the response side at random
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) hold_cnt <= pick_gap();
      end
   end

   // abort on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles,
                  outcome_q.size());
         $display("ble_central_link_tracker: mismatch");
         $finish;
      end
   end

   initial begin
      int i;
      int sel;
      int k;
      calm = 0;
      n_items = 0; n_results = 0; n_scan_hits = 0; n_links_up = 0;
      n_overflow = 0; n_mismatch = 0; cycles = 0; hold_cnt = 0;
      m_link = LINK_IDLE;
      m_handle = NO_HANDLE;
      m_peer = '0;
      m_ptype = '0;
      seen_cnt = 0;
      for (i = 0; i < SLOTS; i++) begin
         seen_ok[i] = 0;
         seen_addr[i] = '0;
      end

      // directed table: the rows from reset up to the first scan start typed in, the rest modeled
      plan_q.push_back('{mk(CMD_STOP_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'h5A, 16'h0000, 1'b0),
                         1, reset_outcome(1'b1, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_DISCONNECT, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         1, reset_outcome(1'b1, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_ADV_REPORT, '1, 8'hFF, 8'h80, 8'hFF, 8'h00, 16'h0000, 1'b0),
                         1, reset_outcome(1'b1, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_CONN_DONE, '1, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h1234, 1'b0),
                         1, reset_outcome(1'b0, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_DISCONN_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, NO_HANDLE, 1'b0),
                         1, reset_outcome(1'b0, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_PROC_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         1, reset_outcome(1'b0, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_PROC_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1),
                         1, reset_outcome(1'b1, REQ_NONE, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_START_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000, 1'b0),
                         1, reset_outcome(1'b0, REQ_START_DISC, LINK_IDLE)});
      plan_q.push_back('{mk(CMD_START_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         1, reset_outcome(1'b1, REQ_START_DISC, LINK_SCAN)});
      plan_q.push_back('{mk(CMD_START_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_ADV_REPORT, '1, 8'hFF, 8'h80, 8'hFF, 8'hFF, 16'hFFFF, 1'b1),
                         0, '0});
      plan_q.push_back('{mk(CMD_ADV_REPORT, '1, 8'h01, 8'h7F, 8'h05, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_ADV_REPORT, '0, 8'h00, 8'h7F, 8'h1F, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_ADV_REPORT, 48'h1, 8'h02, 8'h00, 8'h20, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_CONNECT, 48'h1234, 8'h01, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_STOP_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'h80, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_STOP_SCAN, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_PROC_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1),
                         0, '0});
      plan_q.push_back('{mk(CMD_CONNECT, 48'hA5A5_0000_5A5A, 8'h01, 8'h00, 8'h00, 8'h3E,
                            16'h0000, 1'b0), 0, '0});
      plan_q.push_back('{mk(CMD_CONNECT, 48'hC0DE_0000_0001, 8'h01, 8'h00, 8'h00, 8'h00,
                            16'h0000, 1'b0), 0, '0});
      plan_q.push_back('{mk(CMD_DISCONNECT, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_CONN_DONE, '1, 8'hFF, 8'h00, 8'h00, 8'h3E, 16'h0005, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_CONNECT, 48'h5555_AAAA_5555, 8'h00, 8'h00, 8'h00, 8'h00,
                            16'h0000, 1'b0), 0, '0});
      plan_q.push_back('{mk(CMD_CONN_DONE, 48'hAAAA_5555_AAAA, 8'hFF, 8'h00, 8'h00, 8'h00,
                            16'h0000, 1'b0), 0, '0});
      plan_q.push_back('{mk(CMD_DISCONNECT, '0, 8'h00, 8'h00, 8'h00, 8'h13, 16'h0000, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_DISCONN_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 1'b0),
                         0, '0});
      plan_q.push_back('{mk(CMD_DISCONN_DONE, '0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                         0, '0});

      // hold reset, then release it at a clock edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) send_item(plan_q[i].it, plan_q[i].fixed, plan_q[i].want);

      // random sessions; a calm stretch runs with no idling on either side
      while (n_items < ITEM_TARGET) begin
         calm = ($urandom_range(0, 5) == 0);
         sel = $urandom_range(0, 9);
         if (sel < 5) scan_session();
         else if (sel < 8) connect_session();
         else for (k = $urandom_range(1, 4); k > 0; k--) send(noise_item());
      end
      req_tvalid <= 1'b0;
      calm = 0;

      // drain, then watch for stray responses
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items, %0d responses: %0d new scan results, %0d past a full table,",
               n_items, n_results, n_scan_hits, n_overflow);
      $display("%0d links established, %0d mismatches", n_links_up, n_mismatch);
      if (n_mismatch == 0 && outcome_q.size() == 0)
         $display("ble_central_link_tracker: match");
      else
         $display("ble_central_link_tracker: mismatch");
      $finish;
   end

endmodule
